// ===== rtl/vdm_pkg.sv =====
package vdm_pkg;

    localparam int ELEM_W      = 16;
    localparam int MAIN_W      = 48;
    localparam int NORM_W      = 47;
    localparam int TERM_W      = 34;
    localparam int SQ_W        = 31;
    localparam int COUNT_W     = 11;
    localparam int METRIC_W    = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int MAX_LENGTH  = 1024;
    localparam int COS_BITS    = 14;
    localparam int DIGIT_W     = 16;
    localparam int MUL_STEPS   = 3;
    localparam int PROD_W      = 2 * NORM_W;
    localparam int ROOT_W      = NORM_W;
    localparam int REM_W       = ROOT_W + 2;
    localparam int DIVIDEND_W  = MAIN_W + COS_BITS;
    localparam int STEP_W      = 6;
    localparam int LENGTH_RESET = 128;

    localparam logic [METRIC_W-1:0] METRIC_L2     = 2'd0;
    localparam logic [METRIC_W-1:0] METRIC_DOT    = 2'd1;
    localparam logic [METRIC_W-1:0] METRIC_COSINE = 2'd2;
    localparam logic [METRIC_W-1:0] METRIC_NONE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_METRIC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 2'd1;

    localparam logic signed [MAIN_W-1:0] S48_MAX = {1'b0, {(MAIN_W-1){1'b1}}};
    localparam logic signed [MAIN_W-1:0] S48_MIN = {1'b1, {(MAIN_W-1){1'b0}}};

    typedef struct packed {
        logic signed [MAIN_W-1:0] main_sum;
        logic [NORM_W-1:0]        left_norm;
        logic [NORM_W-1:0]        right_norm;
        logic [METRIC_W-1:0]      metric;
        logic                     length_error;
    } job_t;

endpackage

// ===== rtl/vdm_front.sv =====
module vdm_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [vdm_pkg::ELEM_W-1:0] left_element,
    input  logic signed [vdm_pkg::ELEM_W-1:0] right_element,
    input  logic                          last,
    input  logic [vdm_pkg::METRIC_W-1:0]  metric,
    input  logic [vdm_pkg::COUNT_W-1:0]   vector_length,
    output logic                          job_valid,
    input  logic                          job_ready,
    output vdm_pkg::job_t                 job
);

    logic                                 a_valid_reg, a_valid_next;
    logic signed [vdm_pkg::TERM_W-1:0]    a_term_reg;
    logic [vdm_pkg::SQ_W-1:0]             a_lsq_reg, a_rsq_reg;
    logic                                 a_last_reg;
    logic [vdm_pkg::METRIC_W-1:0]         a_metric_reg;

    logic signed [vdm_pkg::MAIN_W-1:0]    main_reg, main_next;
    logic [vdm_pkg::NORM_W-1:0]           lnorm_reg, lnorm_next, rnorm_reg, rnorm_next;
    logic [vdm_pkg::COUNT_W-1:0]          count_reg, count_next;

    logic signed [vdm_pkg::TERM_W-1:0]    lx, rx, dx, term, lsq, rsq;
    logic signed [vdm_pkg::MAIN_W:0]      msum;
    logic [vdm_pkg::NORM_W:0]             lsum, rsum;
    logic signed [vdm_pkg::MAIN_W-1:0]    main_acc;
    logic [vdm_pkg::NORM_W-1:0]           lnorm_acc, rnorm_acc;
    logic [vdm_pkg::COUNT_W-1:0]          count_acc;
    logic                                 a_fire, in_fire;

    assign lx = vdm_pkg::TERM_W'(left_element);
    assign rx = vdm_pkg::TERM_W'(right_element);
    assign dx = lx - rx;
    assign term = (metric == vdm_pkg::METRIC_L2) ? dx * dx : lx * rx;
    assign lsq = lx * lx;
    assign rsq = rx * rx;

    assign a_fire   = a_valid_reg && (!a_last_reg || job_ready);
    assign in_ready = !a_valid_reg || a_fire;
    assign in_fire  = in_valid && in_ready;
    assign a_valid_next = in_fire ? 1'b1 : (a_fire ? 1'b0 : a_valid_reg);

    always_comb begin
        msum = {main_reg[vdm_pkg::MAIN_W-1], main_reg} + (vdm_pkg::MAIN_W+1)'(a_term_reg);
        if (msum[vdm_pkg::MAIN_W] != msum[vdm_pkg::MAIN_W-1]) begin
            main_acc = msum[vdm_pkg::MAIN_W] ? vdm_pkg::S48_MIN : vdm_pkg::S48_MAX;
        end else begin
            main_acc = msum[vdm_pkg::MAIN_W-1:0];
        end
        lsum = {1'b0, lnorm_reg} + (vdm_pkg::NORM_W+1)'(a_lsq_reg);
        rsum = {1'b0, rnorm_reg} + (vdm_pkg::NORM_W+1)'(a_rsq_reg);
        lnorm_acc = lsum[vdm_pkg::NORM_W] ? {vdm_pkg::NORM_W{1'b1}} : lsum[vdm_pkg::NORM_W-1:0];
        rnorm_acc = rsum[vdm_pkg::NORM_W] ? {vdm_pkg::NORM_W{1'b1}} : rsum[vdm_pkg::NORM_W-1:0];
        count_acc = (&count_reg) ? count_reg : count_reg + 1'b1;

        job.main_sum     = main_acc;
        job.left_norm    = lnorm_acc;
        job.right_norm   = rnorm_acc;
        job.metric       = a_metric_reg;
        job.length_error = (vector_length == '0)
                        || (vector_length > vdm_pkg::COUNT_W'(vdm_pkg::MAX_LENGTH))
                        || (count_acc != vector_length);

        main_next  = main_reg;
        lnorm_next = lnorm_reg;
        rnorm_next = rnorm_reg;
        count_next = count_reg;
        if (a_fire) begin
            if (a_last_reg) begin
                main_next  = '0;
                lnorm_next = '0;
                rnorm_next = '0;
                count_next = '0;
            end else begin
                main_next  = main_acc;
                lnorm_next = lnorm_acc;
                rnorm_next = rnorm_acc;
                count_next = count_acc;
            end
        end
    end

    assign job_valid = a_valid_reg && a_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            main_reg    <= '0;
            lnorm_reg   <= '0;
            rnorm_reg   <= '0;
            count_reg   <= '0;
        end else begin
            a_valid_reg <= a_valid_next;
            main_reg    <= main_next;
            lnorm_reg   <= lnorm_next;
            rnorm_reg   <= rnorm_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            a_term_reg   <= term;
            a_lsq_reg    <= lsq[vdm_pkg::SQ_W-1:0];
            a_rsq_reg    <= rsq[vdm_pkg::SQ_W-1:0];
            a_last_reg   <= last;
            a_metric_reg <= metric;
        end
    end

endmodule

// ===== rtl/vdm_queue.sv =====
module vdm_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  vdm_pkg::job_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output vdm_pkg::job_t rd_data
);

    vdm_pkg::job_t mem_reg [2];
    logic          wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          wr_fire, rd_fire;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rptr_reg];
    assign wr_fire  = wr_valid && wr_ready;
    assign rd_fire  = rd_valid && rd_ready;

    always_comb begin
        wptr_next = wr_fire ? ~wptr_reg : wptr_reg;
        rptr_next = rd_fire ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + 2'(wr_fire) - 2'(rd_fire);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_fire) begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/vdm_back.sv =====
module vdm_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             job_valid,
    output logic                             job_ready,
    input  vdm_pkg::job_t                    job,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [vdm_pkg::MAIN_W-1:0] out_distance,
    output logic                             out_zero_norm,
    output logic                             out_length_error
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SQRT = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]                        state_reg, state_next;
    logic [vdm_pkg::STEP_W-1:0]        step_reg, step_next;
    logic [vdm_pkg::PROD_W-1:0]        rad_reg, rad_next;
    logic [vdm_pkg::REM_W-1:0]         rem_reg, rem_next;
    logic [vdm_pkg::ROOT_W-1:0]        root_reg, root_next;
    logic [vdm_pkg::NORM_W-1:0]        lnorm_reg, lnorm_next, rnorm_reg, rnorm_next;
    logic signed [vdm_pkg::MAIN_W-1:0] main_reg, main_next, dist_reg, dist_next;
    logic [vdm_pkg::METRIC_W-1:0]      metric_reg, metric_next;
    logic                              lerr_reg, lerr_next, zn_reg, zn_next;
    logic                              ov_reg, ov_next;
    logic signed [vdm_pkg::MAIN_W-1:0] od_reg, od_next;
    logic                              ozn_reg, ozn_next, olerr_reg, olerr_next;

    logic [vdm_pkg::DIGIT_W-1:0]                 digit;
    logic [vdm_pkg::NORM_W+vdm_pkg::DIGIT_W-1:0] partial;
    logic [vdm_pkg::PROD_W-1:0]                  shifted;
    logic [vdm_pkg::REM_W+1:0]                   sq_rem, sq_trial;
    logic [vdm_pkg::REM_W-1:0]                   dv_rem;
    logic signed [vdm_pkg::MAIN_W:0]             neg_main;
    logic [vdm_pkg::MAIN_W-1:0]                  main_mag;
    logic signed [63:0]                          qs, cdist;
    logic                                        out_free;

    assign job_ready = (state_reg == ST_IDLE);
    assign out_free  = !ov_reg || out_ready;

    always_comb begin
        unique case (step_reg[1:0])
            2'd0:    digit = rnorm_reg[15:0];
            2'd1:    digit = rnorm_reg[31:16];
            default: digit = vdm_pkg::DIGIT_W'(rnorm_reg[vdm_pkg::NORM_W-1:32]);
        endcase
        partial = vdm_pkg::NORM_W'(lnorm_reg) * digit;
        unique case (step_reg[1:0])
            2'd0:    shifted = vdm_pkg::PROD_W'(partial);
            2'd1:    shifted = vdm_pkg::PROD_W'(partial) << 16;
            default: shifted = vdm_pkg::PROD_W'(partial) << 32;
        endcase

        sq_rem   = {rem_reg, rad_reg[vdm_pkg::PROD_W-1 -: 2]};
        sq_trial = {1'b0, root_reg, 2'b01};
        dv_rem   = {rem_reg[vdm_pkg::REM_W-2:0], rad_reg[vdm_pkg::DIVIDEND_W-1]};

        neg_main = -{main_reg[vdm_pkg::MAIN_W-1], main_reg};
        main_mag = main_reg[vdm_pkg::MAIN_W-1] ? neg_main[vdm_pkg::MAIN_W-1:0]
                                               : main_reg;
        qs    = main_reg[vdm_pkg::MAIN_W-1] ? -$signed(64'(rad_reg[vdm_pkg::DIVIDEND_W-1:0]))
                                            : $signed(64'(rad_reg[vdm_pkg::DIVIDEND_W-1:0]));
        cdist = $signed(64'(1) << vdm_pkg::COS_BITS) - qs;

        state_next  = state_reg;
        step_next   = step_reg;
        rad_next    = rad_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        lnorm_next  = lnorm_reg;
        rnorm_next  = rnorm_reg;
        main_next   = main_reg;
        metric_next = metric_reg;
        lerr_next   = lerr_reg;
        zn_next     = zn_reg;
        dist_next   = dist_reg;
        ov_next     = ov_reg && !out_ready;
        od_next     = od_reg;
        ozn_next    = ozn_reg;
        olerr_next  = olerr_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    main_next   = job.main_sum;
                    lnorm_next  = job.left_norm;
                    rnorm_next  = job.right_norm;
                    metric_next = job.metric;
                    lerr_next   = job.length_error;
                    zn_next     = 1'b0;
                    dist_next   = '0;
                    step_next   = '0;
                    rem_next    = '0;
                    root_next   = '0;
                    rad_next    = '0;
                    unique case (job.metric)
                        vdm_pkg::METRIC_L2: begin
                            if (!job.main_sum[vdm_pkg::MAIN_W-1]) begin
                                rad_next = vdm_pkg::PROD_W'(job.main_sum);
                            end
                            state_next = ST_SQRT;
                        end
                        vdm_pkg::METRIC_DOT: begin
                            neg_main = -{job.main_sum[vdm_pkg::MAIN_W-1], job.main_sum};
                            dist_next = (neg_main[vdm_pkg::MAIN_W] != neg_main[vdm_pkg::MAIN_W-1])
                                      ? vdm_pkg::S48_MAX : neg_main[vdm_pkg::MAIN_W-1:0];
                            state_next = ST_DONE;
                        end
                        vdm_pkg::METRIC_COSINE: begin
                            if (job.left_norm == '0 || job.right_norm == '0) begin
                                zn_next    = 1'b1;
                                state_next = ST_DONE;
                            end else begin
                                state_next = ST_MUL;
                            end
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                rad_next  = rad_reg + shifted;
                step_next = step_reg + 1'b1;
                if (step_reg == vdm_pkg::STEP_W'(vdm_pkg::MUL_STEPS - 1)) begin
                    step_next  = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                rad_next = rad_reg << 2;
                if (sq_rem >= sq_trial) begin
                    rem_next  = vdm_pkg::REM_W'(sq_rem - sq_trial);
                    root_next = {root_reg[vdm_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    rem_next  = vdm_pkg::REM_W'(sq_rem);
                    root_next = {root_reg[vdm_pkg::ROOT_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == vdm_pkg::STEP_W'(vdm_pkg::ROOT_W - 1)) begin
                    step_next = '0;
                    if (metric_reg == vdm_pkg::METRIC_L2) begin
                        dist_next  = vdm_pkg::MAIN_W'(root_next);
                        state_next = ST_DONE;
                    end else begin
                        rem_next   = '0;
                        rad_next   = vdm_pkg::PROD_W'({main_mag, {vdm_pkg::COS_BITS{1'b0}}});
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (dv_rem >= vdm_pkg::REM_W'(root_reg)) begin
                    rem_next = dv_rem - vdm_pkg::REM_W'(root_reg);
                    rad_next = {rad_reg[vdm_pkg::PROD_W-2:0], 1'b1};
                end else begin
                    rem_next = dv_rem;
                    rad_next = {rad_reg[vdm_pkg::PROD_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == vdm_pkg::STEP_W'(vdm_pkg::DIVIDEND_W - 1)) begin
                    step_next  = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (metric_reg == vdm_pkg::METRIC_COSINE && !zn_reg) begin
                    if (cdist > 64'(vdm_pkg::S48_MAX)) begin
                        dist_next = vdm_pkg::S48_MAX;
                    end else if (cdist < 64'(vdm_pkg::S48_MIN)) begin
                        dist_next = vdm_pkg::S48_MIN;
                    end else begin
                        dist_next = cdist[vdm_pkg::MAIN_W-1:0];
                    end
                end
                if (out_free) begin
                    ov_next    = 1'b1;
                    od_next    = dist_next;
                    ozn_next   = zn_reg;
                    olerr_next = lerr_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg    <= rad_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        lnorm_reg  <= lnorm_next;
        rnorm_reg  <= rnorm_next;
        main_reg   <= main_next;
        metric_reg <= metric_next;
        lerr_reg   <= lerr_next;
        zn_reg     <= zn_next;
        dist_reg   <= dist_next;
        od_reg     <= od_next;
        ozn_reg    <= ozn_next;
        olerr_reg  <= olerr_next;
    end

    assign out_valid        = ov_reg;
    assign out_distance     = od_reg;
    assign out_zero_norm    = ozn_reg;
    assign out_length_error = olerr_reg;

    a_zero_norm_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && out_zero_norm |-> out_distance == '0)
        else $error("zero norm result with nonzero distance");

    a_hold_output: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid && $stable(out_distance))
        else $error("pending result changed");

    a_sqrt_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SQRT |-> step_reg < vdm_pkg::STEP_W'(vdm_pkg::ROOT_W))
        else $error("square root step count out of range");

    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid && job_ready |=> state_reg != ST_IDLE)
        else $error("job taken without starting");

endmodule

// ===== rtl/vector_distance_metric_top.sv =====
// Streaming vector distance: one left/right element pair per input word, in
// signed Q3.12, one result word per word marked tlast. The front accumulates
// at one pair per cycle unless a vector's last pair waits for a full job
// queue. The back finishes negated dot, unused metric and zero norm results
// directly, euclidean after a one-bit-per-cycle square root, and cosine after
// a 16-bit-digit norm product, that square root and a restoring divide. A
// two-entry job queue lets the front keep streaming the next vector while the
// back works, so vectors shorter than the back latency throttle the input.
module vector_distance_metric_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [31:0]                      s_tdata,  // left_element, right_element
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [47:0]                      m_tdata,  // distance
    output logic [1:0]                       m_tuser,  // zero_norm, length_error
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [vdm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vdm_pkg::COUNT_W-1:0]      cfg_data
);

    logic [vdm_pkg::METRIC_W-1:0]      metric_reg, metric_next;
    logic [vdm_pkg::COUNT_W-1:0]       vlen_reg, vlen_next;
    logic                              fq_valid, fq_ready, qb_valid, qb_ready;
    vdm_pkg::job_t                     fq_job, qb_job;
    logic signed [vdm_pkg::MAIN_W-1:0] out_distance;
    logic                              zero_norm, length_error;

    assign cfg_ready = 1'b1;

    always_comb begin
        metric_next = metric_reg;
        vlen_next   = vlen_reg;
        if (cfg_valid) begin
            if (cfg_index == vdm_pkg::CFG_METRIC) begin
                metric_next = cfg_data[vdm_pkg::METRIC_W-1:0];
            end else if (cfg_index == vdm_pkg::CFG_LENGTH) begin
                vlen_next = cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            metric_reg <= vdm_pkg::METRIC_L2;
            vlen_reg   <= vdm_pkg::COUNT_W'(vdm_pkg::LENGTH_RESET);
        end else begin
            metric_reg <= metric_next;
            vlen_reg   <= vlen_next;
        end
    end

    vdm_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .left_element  ($signed(s_tdata[15:0])),
        .right_element ($signed(s_tdata[31:16])),
        .last          (s_tlast),
        .metric        (metric_reg),
        .vector_length (vlen_reg),
        .job_valid     (fq_valid),
        .job_ready     (fq_ready),
        .job           (fq_job)
    );

    vdm_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_job),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_job)
    );

    vdm_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .job_valid        (qb_valid),
        .job_ready        (qb_ready),
        .job              (qb_job),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_distance     (out_distance),
        .out_zero_norm    (zero_norm),
        .out_length_error (length_error)
    );

    assign m_tdata = out_distance;
    assign m_tuser = {length_error, zero_norm};

endmodule
